// ===== rtl/dzv_pkg.sv =====
// ----------------------------------------------------------------------------
// dzv_pkg: shared definitions for the delta/zigzag/varint encoder
// Types, opcodes and sizes used by the front end, the job queue and the
// byte emitter.
// ----------------------------------------------------------------------------
package dzv_pkg;

    localparam int ID_W       = 64;
    localparam int COUNT_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int GROUP_W    = 7;
    localparam int QUEUE_DEPTH = 2;

    // Opcode carried in the op field of an input item.
    localparam logic OP_START = 1'b0;
    localparam logic OP_ID    = 1'b1;

    // One unit of work for the emitter: the unsigned value to be sent as a varint.
    typedef struct packed {
        logic [ID_W-1:0] value;
    } t_job;

    // Queue status seen by its producer and its consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/dzv_in_if.sv =====
// ----------------------------------------------------------------------------
// dzv_in_if: input channel of the encoder
// Valid/ready channel carrying one start or id item.
// ----------------------------------------------------------------------------
interface dzv_in_if;
    logic                valid;
    logic                ready;
    logic                op;
    logic signed [63:0]  node_id;
    logic        [15:0]  node_count;

    modport source (output valid, output op, output node_id, output node_count,
                    input ready);
    modport sink   (input valid, input op, input node_id, input node_count,
                    output ready);
endinterface

// ===== rtl/dzv_out_if.sv =====
// ----------------------------------------------------------------------------
// dzv_out_if: output channel of the encoder
// Valid/ready channel carrying one byte of the encoded stream.
// ----------------------------------------------------------------------------
interface dzv_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== rtl/dzv_front.sv =====
// ----------------------------------------------------------------------------
// dzv_front: item intake and classification
// Accepts items, forms the zigzag-mapped delta or the list length, and
// hands the resulting value to the job queue.
// ----------------------------------------------------------------------------
module dzv_front
    import dzv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    dzv_in_if.sink   i_in,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_job     o_push_job
);

    logic            r_valid;
    t_job            r_job;
    logic [ID_W-1:0] r_prev;
    t_job            n_job;
    logic [ID_W-1:0] n_prev;
    logic [ID_W-1:0] w_delta;
    logic            w_accept;

    assign o_push     = r_valid && !i_q_stat.full;
    assign i_in.ready = !r_valid || !i_q_stat.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_delta    = i_in.node_id - r_prev;

    always_comb begin
        if (i_in.op == OP_START) begin
            n_job.value = {{(ID_W-COUNT_W){1'b0}}, i_in.node_count};
            n_prev      = '0;
        end else begin
            // Zigzag: shift left one place and fold in the sign.
            n_job.value = {w_delta[ID_W-2:0], 1'b0} ^ {ID_W{w_delta[ID_W-1]}};
            n_prev      = i_in.node_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= '0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
            r_prev  <= n_prev;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= n_job;
        end
    end

    assign o_push_job = r_job;

endmodule

// ===== rtl/dzv_queue.sv =====
// ----------------------------------------------------------------------------
// dzv_queue: job queue between front end and emitter
// Small first-in first-out buffer of values waiting to be emitted.
// ----------------------------------------------------------------------------
module dzv_queue
    import dzv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_job     i_push_job,
    input  logic     i_pop,
    output t_job     o_head,
    output t_q_stat  o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // The fill level never goes beyond the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue fill level beyond depth");

    // Producer never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("push into full queue");

    // Consumer never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("pop from empty queue");

    // A push without a pop raises the fill level by one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("fill level did not follow a push");

endmodule

// ===== rtl/dzv_back.sv =====
// ----------------------------------------------------------------------------
// dzv_back: varint byte emitter
// Takes values from the job queue and sends them seven bits at a time,
// least significant group first, through a registered output stage.
// ----------------------------------------------------------------------------
module dzv_back
    import dzv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job     i_head,
    input  t_q_stat  i_q_stat,
    output logic     o_pop,
    dzv_out_if.source o_out
);

    logic              r_busy;
    logic [ID_W-1:0]   r_val;
    logic              r_ovalid;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_olast;
    logic [ID_W-1:0]   w_cur;
    logic              w_has;
    logic              w_adv;
    logic              w_step;
    logic              w_last;

    // Continue the value in progress, or start the one at the queue head.
    assign w_cur  = r_busy ? r_val : i_head.value;
    assign w_has  = r_busy || !i_q_stat.empty;
    assign w_adv  = !r_ovalid || o_out.ready;
    assign w_step = w_adv && w_has;
    assign w_last = (w_cur[ID_W-1:GROUP_W] == '0);
    assign o_pop  = w_step && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (w_step) begin
            r_busy   <= !w_last;
            r_ovalid <= 1'b1;
        end else if (w_adv) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_val   <= w_cur >> GROUP_W;
            r_obyte <= {!w_last, w_cur[GROUP_W-1:0]};
            r_olast <= w_last;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.out_byte  = r_obyte;
    assign o_out.last_byte = r_olast;

    // A continuation byte is always followed by more of the same value.
    a_cont_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !w_last) |=> r_busy)
        else $error("emitter idle after a continuation byte");

    // The continuation flag and the last flag are never set together.
    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_obyte[BYTE_W-1] == !r_olast))
        else $error("continuation flag disagrees with last flag");

endmodule

// ===== rtl/delta_zigzag_varint_encoder.sv =====
// ----------------------------------------------------------------------------
// delta_zigzag_varint_encoder: node id list encoder
// Turns start and id items into a base-128 varint byte stream of the list
// length and the zigzag-mapped deltas between successive ids.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Payload
//  i_in     in   valid/ready    op, node_id (signed 64), node_count (16)
//  o_out    out  valid/ready    out_byte (8), last_byte (1)
//
//  Each item yields one to ten bytes, one byte per clock while the output
//  is ready. The front end takes one item per clock until the two-entry
//  queue and its own register are full. Reset is synchronous and active
//  low; it clears the previous id to zero. A stalled output holds its byte;
//  the front end keeps accepting until the queue and its own register are
//  full.
//
// ----------------------------------------------------------------------------
module delta_zigzag_varint_encoder
    import dzv_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dzv_in_if.sink    i_in,
    dzv_out_if.source o_out
);

    // Value handed from the front end into the queue, and the queue head.
    logic    w_push;
    t_job    w_push_job;
    logic    w_pop;
    t_job    w_head;
    t_q_stat w_q_stat;

    // The front end forms the delta against the stored previous id and
    // zigzag-maps it; a start item passes its count through and clears
    // the previous id instead.
    dzv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_push_job (w_push_job)
    );

    // The queue decouples intake from emission so that a stalled output
    // does not stop the front end at once.
    dzv_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_stat     (w_q_stat)
    );

    // The emitter shifts each value out seven bits per byte and takes the next
    // value from the queue head only after the last byte of the previous one.
    dzv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule

// ===== dv/tb_delta_zigzag_varint_encoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delta_zigzag_varint_encoder: self-checking bench for the node id encoder
// Drives start and id items into the encoder. A model of the delta, zigzag
// and varint stages works out the bytes that each item must produce. Every
// byte that leaves the block is compared with the oldest byte still awaited.
// Both channels stall at random, and the output is once held off long enough
// to fill the block.
// ----------------------------------------------------------------------------
module tb_delta_zigzag_varint_encoder;
    import dzv_pkg::*;

    localparam int              TAIL_CYCLES = 40;
    localparam int              HOLD_CYCLES = 300;
    localparam int              MAX_GAP     = 11;
    localparam logic [ID_W-1:0] ID_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ID_W-1:0] ID_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [ID_W-1:0] ID_ALL_ONES = '1;

    // One byte of the encoded stream as the block should present it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_stream_byte;

    logic i_clk;
    logic i_rst_n;

    dzv_in_if  id_in ();
    dzv_out_if byte_out ();

    delta_zigzag_varint_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (id_in),
        .o_out   (byte_out)
    );

    // Bytes still awaited, oldest first, and the model's copy of the previous id.
    t_stream_byte    expected_bytes[$];
    logic [ID_W-1:0] model_prev_id = '0;

    int mismatch_count    = 0;
    bit sender_gaps_on    = 1'b0;
    bit receiver_gaps_on  = 1'b0;
    int receiver_hold_req = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The run must end well inside this time even with every stall at its
    // longest and every item producing ten bytes.
    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Works out the bytes for one accepted item. A start item clears the
    // previous id and encodes the count; an id item encodes the zigzag-mapped
    // difference from the previous id, which wraps modulo 2^64.
    function automatic void predict_varint_bytes(input logic            op,
                                                 input logic [ID_W-1:0] node_id,
                                                 input logic [COUNT_W-1:0] count);
        logic [ID_W-1:0] value;
        logic [ID_W-1:0] delta;
        logic [ID_W-1:0] rest;
        t_stream_byte    entry;
        logic            more;
        if (op == OP_START) begin
            model_prev_id = '0;
            value         = {{(ID_W-COUNT_W){1'b0}}, count};
        end else begin
            delta         = node_id - model_prev_id;
            value         = (delta << 1) ^ {ID_W{delta[ID_W-1]}};
            model_prev_id = node_id;
        end
        // Seven bits per byte, least significant group first; the top bit
        // marks that another byte of the same value follows.
        more = 1'b1;
        while (more) begin
            rest       = value >> GROUP_W;
            more       = (rest != '0);
            entry.data = {more, value[GROUP_W-1:0]};
            entry.last = !more;
            expected_bytes.insert(expected_bytes.size(), entry);
            value      = rest;
        end
    endfunction

    // Offers one item and returns at the edge that accepts it. Valid stays high
    // on return, so back-to-back items keep it asserted without a dip.
    task automatic send_item(input logic            op,
                             input logic [ID_W-1:0] node_id,
                             input logic [COUNT_W-1:0] count);
        if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
            id_in.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        id_in.valid      <= 1'b1;
        id_in.op         <= op;
        id_in.node_id    <= node_id;
        id_in.node_count <= count;
        do @(posedge i_clk); while (!id_in.ready);
        predict_varint_bytes(op, node_id, count);
    endtask

    // Stops offering items and waits until every awaited byte has arrived.
    task automatic idle_until_drained();
        id_in.valid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
    endtask

    // Picks the next id of a list. Most picks lie close to the previous id, as
    // in real id lists, so that short varints dominate; the rest are wide jumps,
    // fully random values, the extremes of the signed range, zero and minus one.
    function automatic logic [ID_W-1:0] pick_node_id(input logic [ID_W-1:0] prev);
        longint          step;
        logic [ID_W-1:0] pick;
        case ($urandom_range(0, 6))
            0, 1, 2: begin
                step = longint'($urandom_range(0, 2000)) - 1000;
                pick = prev + step;
            end
            3: begin
                step = longint'($signed($urandom));
                pick = prev + step;
            end
            4: pick = {$urandom, $urandom};
            5: begin
                case ($urandom_range(0, 3))
                    0:       pick = ID_MIN;
                    1:       pick = ID_MAX;
                    2:       pick = '0;
                    default: pick = ID_ALL_ONES;
                endcase
            end
            default: pick = prev;
        endcase
        return pick;
    endfunction

    // Length extremes, group boundaries, ids before any start item, a zero
    // delta, wraparound at both ends of the signed range and lists whose count
    // does not match the ids that follow.
    task automatic test_directed_cases();
        send_item(OP_ID,    64'd5, '0);
        send_item(OP_ID,    64'd5, '0);
        send_item(OP_START, '0, 16'd0);
        send_item(OP_START, '0, 16'd127);
        send_item(OP_START, '0, 16'd128);
        send_item(OP_START, '0, 16'hFFFF);
        send_item(OP_ID,    '0, '0);
        send_item(OP_ID,    ID_ALL_ONES, '0);
        send_item(OP_ID,    '0, '0);
        send_item(OP_ID,    ID_MAX, '0);
        send_item(OP_ID,    ID_MIN, '0);
        send_item(OP_ID,    '0, '0);
        send_item(OP_ID,    ID_MIN, '0);
        send_item(OP_ID,    ID_MAX, '0);
        send_item(OP_START, '0, 16'd2);
        send_item(OP_ID,    64'd64, '0);
        send_item(OP_ID,    -64'sd64, '0);
        send_item(OP_ID,    64'd100, '0);
        send_item(OP_START, '0, 16'd3);
        send_item(OP_ID,    64'd1, '0);
        send_item(OP_START, '0, 16'd1);
        send_item(OP_START, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA);
        send_item(OP_START, 64'h5555_5555_5555_5555, 16'h5555);
    endtask

    // Mostly well-formed lists with random content: a start item, then as many
    // ids as it announces. Long announced lists are cut short, some lists get
    // one id too many or too few, and now and then a stray id arrives between
    // lists. Unused fields carry random junk.
    task automatic test_random_lists(input int item_goal);
        int                 sent;
        int                 ids_left;
        logic [COUNT_W-1:0] count;
        logic [ID_W-1:0]    list_prev;
        logic [ID_W-1:0]    next_id;
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(0, 9) == 0) begin
                next_id = pick_node_id(model_prev_id);
                send_item(OP_ID, next_id, COUNT_W'($urandom));
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                count = COUNT_W'($urandom);
            else
                count = COUNT_W'($urandom_range(0, 6));
            send_item(OP_START, {$urandom, $urandom}, count);
            sent++;
            ids_left = (count <= 8) ? int'(count) : $urandom_range(0, 8);
            case ($urandom_range(0, 7))
                0:       ids_left++;
                1:       if (ids_left > 0) ids_left--;
                default: ;
            endcase
            list_prev = '0;
            while (ids_left > 0 && sent < item_goal) begin
                next_id = pick_node_id(list_prev);
                send_item(OP_ID, next_id, COUNT_W'($urandom));
                list_prev = next_id;
                ids_left--;
                sent++;
            end
        end
    endtask

    // The receiver holds off for a long stretch while extreme ids keep coming,
    // so the queue fills and the input must stall. The sender then pauses until
    // the whole backlog has drained before it offers anything more.
    task automatic test_output_backpressure();
        bit saved_gaps;
        saved_gaps        = sender_gaps_on;
        sender_gaps_on    = 1'b0;
        receiver_hold_req = HOLD_CYCLES;
        send_item(OP_START, '0, 16'd10);
        for (int k = 0; k < 10; k++) begin
            if (k % 2 == 0)
                send_item(OP_ID, ID_MAX - k, '0);
            else
                send_item(OP_ID, ID_MIN + k, '0);
        end
        idle_until_drained();
        send_item(OP_ID, ID_MAX, '0);
        send_item(OP_START, '0, 16'd1);
        sender_gaps_on = saved_gaps;
    endtask

    // Closing stretch with neither side idling, so items and bytes flow at the
    // block's full rate.
    task automatic test_back_to_back();
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b0;
        test_random_lists(30);
    endtask

    // Receiver: ready is high unless a random stall burst or a requested long
    // hold is in progress. The hold is counted here, independent of the sender.
    initial begin : byte_receiver
        byte_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (receiver_hold_req > 0) begin
                byte_out.ready <= 1'b0;
                repeat (receiver_hold_req) @(posedge i_clk);
                receiver_hold_req = 0;
                byte_out.ready <= 1'b1;
            end else if (receiver_gaps_on && $urandom_range(0, 4) == 0) begin
                byte_out.ready <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
                byte_out.ready <= 1'b1;
            end else begin
                byte_out.ready <= 1'b1;
            end
        end
    end

    // Every byte taken from the block is matched against the oldest awaited byte.
    always @(posedge i_clk) begin : byte_checker
        t_stream_byte want;
        if (i_rst_n && byte_out.valid && byte_out.ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", byte_out.out_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (byte_out.out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                              byte_out.out_byte, want.data));
                if (byte_out.last_byte !== want.last)
                    report_mismatch($sformatf("last_byte %0b, wanted %0b on byte %02h",
                                              byte_out.last_byte, want.last, want.data));
            end
        end
    end

    initial begin : stimulus
        id_in.valid      <= 1'b0;
        id_in.op         <= OP_START;
        id_in.node_id    <= '0;
        id_in.node_count <= '0;
        i_rst_n          <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        test_directed_cases();
        test_random_lists(190);
        test_output_backpressure();
        test_back_to_back();

        idle_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
